@@ sv/tmvm_pkg.sv @@
// Shared constants for the trimmed mean voltage monitor.
package tmvm_pkg;

  // Sample and register widths.
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned SEND_W      = 8;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned MV_W        = 16;
  localparam int unsigned USED_W      = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // Full-scale code is 4096, so the final scale is a right shift.
  localparam int unsigned SCALE_SHIFT = 12;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_EVERY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VCC_SCALE  = 2'd1;

  // Reset values of the registers.
  localparam logic [SEND_W-1:0]  SEND_EVERY_RST = 8'd4;
  localparam logic [SCALE_W-1:0] VCC_SCALE_RST  = 16'd6600;

endpackage

@@ sv/tmvm_ring.sv @@
// Sample ring memory with per-entry valid bits and a registered read port.
module tmvm_ring import tmvm_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PTR_W = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [PTR_W-1:0]    waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic                re_i,
  input  logic [PTR_W-1:0]    raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [SAMPLE_W-1:0] rdata_q;
  logic                rvalid_q;

  // Entries never written since reset read as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

`ifndef SYNTHESIS
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |-> (32'(waddr_i) < DEPTH))
    else $error("ring write address beyond depth");
  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> valid_q[$past(waddr_i)])
    else $error("written entry not marked valid");
`endif

endmodule

@@ sv/tmvm_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module tmvm_divider #(
  parameter int unsigned DIVIDEND_W = 33,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, div_q;
  logic [DIVISOR_W:0]    shifted, diff;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == STEP_W'(DIVIDEND_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // Subtract where the partial remainder allows it, else restore.
      if (shifted >= {1'b0, div_q}) begin
        rem_q <= diff[DIVISOR_W-1:0];
        quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DIVISOR_W-1:0];
        quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

@@ sv/trimmed_mean_voltage_monitor_unit.sv @@
// Top level of the trimmed mean voltage monitor: sequencer, accumulator and registers.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / adc_code_i): one beat carries one
//   12-bit converter sample. The sample overwrites the oldest ring entry; a zero
//   sample marks its slot empty.
//   Output channel (out_valid_o / out_ready_i): one beat carries average_mv_o and
//   samples_used_o, given once every send_every samples when the ring is not empty.
//   Configuration channel (cfg_valid_i / cfg_ready_o): index 0 writes send_every,
//   index 1 writes vcc_scale_mv; other indexes are dropped. Always ready.
// Sequence
//   A sample that triggers no scan is written and the input stays ready. A scanning
//   sample holds the input while the sequencer makes one memory read per ring entry
//   through the single read port, trims, scales, then runs the restoring divider,
//   one bit per cycle over the PROD_W = 28 + clog2(WINDOW + 1) bit dividend.
// Reset
//   Valid bits clear at once, so the ring reads empty; pointer and counter go to
//   zero and the registers take their defaults. No clearing pass is needed.
// Stall
//   A finished result waits in the output register; new samples are still taken.
//   If a further result is ready before the first is taken, the sequencer holds.
module trimmed_mean_voltage_monitor_unit import tmvm_pkg::*; #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   adc_code_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MV_W-1:0]       average_mv_o,
  output logic [USED_W-1:0]     samples_used_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PTR_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned PROD_W = SUM_W + SCALE_W;
  localparam int unsigned EXT_W  = CNT_W + USED_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_CALC, ST_MUL, ST_DSTART, ST_DWAIT, ST_FINISH
  } state_e;

  state_e              state_q;
  logic [SEND_W-1:0]   send_every_q, send_cnt_q, send_cnt_inc;
  logic [SCALE_W-1:0]  vcc_scale_q;
  logic [PTR_W-1:0]    wptr_q, scan_addr_q;
  logic                acc_en_q;
  logic [SUM_W-1:0]    sum_q, kept_sum_q;
  logic [CNT_W-1:0]    cnt_q, kept_cnt_q;
  logic [SAMPLE_W-1:0] lo_q, hi_q, rd_data;
  logic [USED_W-1:0]   used_q;
  logic [PROD_W-1:0]   prod_q, quotient;
  logic                out_valid_q;
  logic [MV_W-1:0]     average_mv_q;
  logic [USED_W-1:0]   samples_used_q;
  logic                in_fire, scan_hit, div_start, div_busy, div_done, out_load;
  logic [EXT_W-1:0]    cnt_ext;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign send_cnt_inc = send_cnt_q + 1'b1;
  assign scan_hit     = (send_cnt_inc == send_every_q);
  assign div_start    = (state_q == ST_DSTART);
  assign out_load     = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign cnt_ext      = EXT_W'(cnt_q);
  assign cfg_ready_o  = 1'b1;

  tmvm_ring #(
    .DEPTH (WINDOW),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_fire),
    .waddr_i (wptr_q),
    .wdata_i (adc_code_i),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (scan_addr_q),
    .rdata_o (rd_data)
  );

  tmvm_divider #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (kept_cnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_every_q <= SEND_EVERY_RST;
      vcc_scale_q  <= VCC_SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEND_EVERY: send_every_q <= cfg_data_i[SEND_W-1:0];
        CFG_VCC_SCALE:  vcc_scale_q  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: write the sample, scan the ring, trim, scale, divide, hand over.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      send_cnt_q  <= '0;
      scan_addr_q <= '0;
      acc_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_en_q <= (state_q == ST_SCAN);
      // Raise valid on a new result, drop it once the beat is taken.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            wptr_q <= (wptr_q == PTR_W'(WINDOW - 1)) ? '0 : wptr_q + 1'b1;
            if (scan_hit) begin
              send_cnt_q  <= '0;
              scan_addr_q <= '0;
              state_q     <= ST_SCAN;
            end else begin
              send_cnt_q <= send_cnt_inc;
            end
          end
        end
        ST_SCAN: begin
          scan_addr_q <= scan_addr_q + 1'b1;
          if (scan_addr_q == PTR_W'(WINDOW - 1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_q <= ST_CALC;
        ST_CALC: begin
          // Empty ring: drop the result.
          state_q <= (cnt_q == '0) ? ST_IDLE : ST_MUL;
        end
        ST_MUL:    state_q <= ST_DSTART;
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: accumulate the scan, trim, multiply and capture the result.
  always_ff @(posedge clk_i) begin
    if (in_fire && scan_hit) begin
      sum_q <= '0;
      cnt_q <= '0;
      lo_q  <= '0;
      hi_q  <= '0;
    end else if (acc_en_q && (rd_data != '0)) begin
      sum_q <= sum_q + SUM_W'(rd_data);
      cnt_q <= cnt_q + 1'b1;
      if ((cnt_q == '0) || (rd_data < lo_q)) begin
        lo_q <= rd_data;
      end
      if ((cnt_q == '0) || (rd_data > hi_q)) begin
        hi_q <= rd_data;
      end
    end
    if (state_q == ST_CALC) begin
      if (cnt_q > CNT_W'(2)) begin
        kept_sum_q <= sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
        kept_cnt_q <= cnt_q - CNT_W'(2);
      end else begin
        kept_sum_q <= sum_q;
        kept_cnt_q <= cnt_q;
      end
      used_q <= (cnt_ext > EXT_W'(31)) ? USED_W'(31) : cnt_ext[USED_W-1:0];
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(kept_sum_q) * PROD_W'(vcc_scale_q);
    end
    if (out_load) begin
      average_mv_q   <= quotient[SCALE_SHIFT +: MV_W];
      samples_used_q <= used_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_mv_o   = average_mv_q;
  assign samples_used_o = samples_used_q;

`ifndef SYNTHESIS
  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (samples_used_o != '0))
    else $error("result with no samples");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (32'(cnt_q) <= WINDOW))
    else $error("scan counted more entries than the ring holds");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DSTART) |=> div_busy)
    else $error("divider not busy after start");
`endif

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the trimmed mean voltage monitor unit.
`timescale 1ns / 1ps

module tb;
  import tmvm_pkg::*;

  localparam int unsigned WINDOW        = 16;
  localparam int unsigned SETTLE_CYCLES = 80;      // longer than one scan and divide
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  // Indexes with no register behind them; beats to these must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [MV_W-1:0]   average_mv;
    logic [USED_W-1:0] samples_used;
  } voltage_report_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   adc_code_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [MV_W-1:0]       average_mv_o;
  logic [USED_W-1:0]     samples_used_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  // Predictor state: our own copy of the ring, pointer, counter and registers.
  logic [SAMPLE_W-1:0] ring_copy [WINDOW];
  int unsigned         ring_wr_ptr;
  logic [SEND_W-1:0]   period_count;
  logic [SEND_W-1:0]   report_period;
  logic [SCALE_W-1:0]  full_scale_mv;

  voltage_report_t pending_reports[$];

  // Traffic shaping knobs, set per test.
  int unsigned gap_max;
  int unsigned burst_max;
  int unsigned burst_left;
  int unsigned stall_max;
  int unsigned stall_left;

  int unsigned cycle_count;
  int unsigned samples_sent;
  int unsigned reports_seen;
  int unsigned reg_writes;
  int unsigned error_count;

  trimmed_mean_voltage_monitor_unit #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .adc_code_i    (adc_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_mv_o  (average_mv_o),
    .samples_used_o(samples_used_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
  end

  // Give up if the run hangs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Sample write into the ring; on a counter match, scan and work out the trimmed mean.
  function automatic void predict_sample(input logic [SAMPLE_W-1:0] code);
    int unsigned     live;
    longint unsigned total;
    longint unsigned kept_total;
    int unsigned     kept_live;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] highest;
    longint unsigned millivolts;
    voltage_report_t report;
    ring_copy[ring_wr_ptr] = code;
    ring_wr_ptr = (ring_wr_ptr + 1) % WINDOW;
    period_count = period_count + 1'b1;
    if (period_count != report_period) return;
    period_count = '0;
    live    = 0;
    total   = 0;
    lowest  = '0;
    highest = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (ring_copy[i] == '0) continue;   // zero slot counts as empty
      total += ring_copy[i];
      if (live == 0 || ring_copy[i] < lowest) lowest = ring_copy[i];
      if (live == 0 || ring_copy[i] > highest) highest = ring_copy[i];
      live++;
    end
    if (live == 0) return;                // empty ring: scan gives nothing
    if (live > 2) begin
      kept_total = total - lowest - highest;
      kept_live  = live - 2;
    end else begin
      kept_total = total;
      kept_live  = live;
    end
    millivolts = (kept_total * full_scale_mv) / (64'd4096 * kept_live);
    report.average_mv   = millivolts[MV_W-1:0];
    report.samples_used = (live > 31) ? 5'd31 : live[USED_W-1:0];
    pending_reports.push_back(report);
  endfunction

  // Receiver: take reports, stalling in random stretches whose length is drawn from stall_max.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stall_max != 0 && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, stall_max);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check every accepted report beat against the oldest prediction.
  always @(posedge clk_i) begin : check_reports
    voltage_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $error("report beat with nothing predicted: average_mv %0d samples_used %0d",
               average_mv_o, samples_used_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (average_mv_o !== want.average_mv) begin
          $error("average_mv: expected %0d, got %0d", want.average_mv, average_mv_o);
          error_count++;
        end
        if (samples_used_o !== want.samples_used) begin
          $error("samples_used: expected %0d, got %0d", want.samples_used, samples_used_o);
          error_count++;
        end
      end
    end
  end

  // Send one sample beat; open a fresh burst after a random gap when the last one ran out.
  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, burst_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    adc_code_i <= code;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_sample(code);
    samples_sent++;
  endtask

  // Hold the sender until every predicted report has arrived.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a scan that yields nothing finish before touching registers.
  task automatic wait_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers, optionally poking a spare index first; valid stays high across beats.
  task automatic write_settings(input logic [CFG_DATA_W-1:0] period_word,
                                input logic [CFG_DATA_W-1:0] scale_word,
                                input bit                    poke_spare);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] data [3];
    int unsigned first;
    idx[0]  = ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
    data[0] = CFG_DATA_W'($urandom());
    idx[1]  = CFG_SEND_EVERY;
    data[1] = period_word;
    idx[2]  = CFG_VCC_SCALE;
    data[2] = scale_word;
    first   = poke_spare ? 0 : 1;
    for (int b = first; b < 3; b++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[b];
      cfg_data_i  <= data[b];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      reg_writes++;
      if (idx[b] == CFG_SEND_EVERY) report_period = data[b][SEND_W-1:0];
      else if (idx[b] == CFG_VCC_SCALE) full_scale_mv = data[b];
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly plausible supply codes, with a good share of empties and rail values.
  function automatic logic [SAMPLE_W-1:0] pick_code(input logic [SAMPLE_W-1:0] centre);
    int unsigned roll;
    int          near;
    roll = $urandom_range(0, 99);
    if (roll < 12) return '0;
    if (roll < 17) return '1;
    if (roll < 20) return 12'd1;
    if (roll < 55) begin
      near = int'(centre) + $urandom_range(0, 64) - 32;
      if (near < 1) near = 1;
      if (near > 4095) near = 4095;
      return near[SAMPLE_W-1:0];
    end
    return SAMPLE_W'($urandom_range(1, 4095));
  endfunction

  // Empty scan, single and pair averages, then a trimmed window, all at reset settings.
  task automatic test_reset_defaults();
    gap_max   = 2;
    burst_max = 4;
    stall_max = 3;
    repeat (4) send_sample('0);          // scan finds an empty ring
    send_sample('1);
    repeat (3) send_sample('0);          // one live entry: mean of itself
    send_sample(12'd1);
    repeat (3) send_sample('0);          // two live entries: no trimming
    send_sample('1);
    send_sample(12'd1);
    send_sample(12'h800);
    send_sample(12'h555);                // six live entries: drop one min, one max
  endtask

  // Register extremes: largest and zero scale, shortest period, masked period byte.
  task automatic test_register_extremes();
    wait_idle();
    write_settings(16'd1, 16'hFFFF, 1'b1);
    send_sample(12'hAAA);
    send_sample('1);
    wait_idle();
    write_settings(16'd1, 16'd0, 1'b1);  // zero scale forces a zero reading
    send_sample(12'h3C7);
    send_sample(12'h001);
    wait_idle();
    write_settings(16'hA5FF, 16'd1, 1'b1);  // upper byte ignored: period 255
  endtask

  // A phase of random samples under one setting, with a full drain now and then.
  task automatic test_random_phase(input int unsigned           count,
                                   input logic [CFG_DATA_W-1:0] period_word,
                                   input logic [CFG_DATA_W-1:0] scale_word,
                                   input int unsigned           gaps,
                                   input int unsigned           bursts,
                                   input int unsigned           stalls);
    logic [SAMPLE_W-1:0] centre;
    wait_idle();
    write_settings(period_word, scale_word, $urandom_range(0, 1) != 0);
    gap_max   = gaps;
    burst_max = bursts;
    stall_max = stalls;
    centre    = SAMPLE_W'($urandom_range(200, 3900));
    for (int n = 0; n < count; n++) begin
      if (n % 97 == 96) begin
        hold_until_drained();
        centre = SAMPLE_W'($urandom_range(200, 3900));
      end
      send_sample(pick_code(centre));
    end
  endtask

  // Lower the period under a running counter: it must wrap through 256 before matching.
  task automatic test_lowered_period();
    test_random_phase(40, 16'd250, 16'd3300, 1, 8, 2);
    wait_idle();
    write_settings(16'd5, 16'd5000, 1'b0);
    for (int n = 0; n < 260; n++) send_sample(pick_code(12'd2048));
  endtask

  initial begin
    for (int i = 0; i < WINDOW; i++) ring_copy[i] = '0;
    ring_wr_ptr   = 0;
    period_count  = '0;
    report_period = SEND_EVERY_RST;
    full_scale_mv = VCC_SCALE_RST;
    gap_max       = 0;
    burst_max     = 1;
    burst_left    = 0;
    stall_max     = 0;
    stall_left    = 0;
    cycle_count   = 0;
    samples_sent  = 0;
    reports_seen  = 0;
    reg_writes    = 0;
    error_count   = 0;

    // Hold reset at first, release it on an edge, and never assert it again.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_phase(150, 16'd255, 16'd1, 3, 6, 4);
    test_random_phase(100, 16'd4, 16'd6600, 0, 1, 0);        // no idling at all
    test_random_phase(250, 16'd1, 16'hFFFF, 4, 5, 12);
    test_random_phase(200, 16'd2, 16'($urandom_range(1, 65535)), 6, 10, 30);
    test_random_phase(200, 16'd16, 16'($urandom_range(1, 65535)), 2, 20, 6);
    test_random_phase(150, 16'd17, 16'($urandom_range(1, 65535)), 10, 3, 20);
    test_random_phase(260, 16'd0, 16'($urandom_range(1, 65535)), 1, 30, 3);
    test_lowered_period();

    // Final drain, then allow one more scan to finish in case it yields nothing.
    wait_idle();

    $display("Covered %0d samples and %0d report beats across %0d register beats,",
             samples_sent, reports_seen, reg_writes);
    $display("periods 0, 1, 2, 4, 5, 16, 17, 250 and 255, scales 0 to full range.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ trimmed_mean_voltage_monitor_unit.f @@
sv/tmvm_pkg.sv
sv/tmvm_ring.sv
sv/tmvm_divider.sv
sv/trimmed_mean_voltage_monitor_unit.sv
sim/tb.sv
